@@ rtl/btr_pkg.sv @@
// Shared types and constants for the block rotation transform unit.
// Holds number formats, port word structs, control enums and the derived datapath widths.
// No dependencies.
package btr_pkg;

  // Number formats
  localparam int VALUE_WIDTH    = 32;
  localparam int AXIS_FRAC_BITS = 30;
  localparam int PARTIAL_WIDTH  = 48;
  localparam int NUM_LANES      = 3;

  // Datapath widths: lane data carries a partial product row entry or a sign-extended value
  localparam int DATA_W = (PARTIAL_WIDTH > VALUE_WIDTH) ? PARTIAL_WIDTH : VALUE_WIDTH;
  localparam int LO_W   = DATA_W / 2;
  localparam int HI_W   = DATA_W - LO_W;
  localparam int MLO_W  = LO_W + 1 + VALUE_WIDTH;
  localparam int MHI_W  = HI_W + VALUE_WIDTH;
  localparam int FULL_W = DATA_W + VALUE_WIDTH + 1;
  localparam int RND_W  = FULL_W - AXIS_FRAC_BITS;
  localparam int SUM_W  = RND_W + 2;

  // Last row / last product step of a 3x3 pass
  localparam logic [1:0] LAST_IDX = 2'(NUM_LANES - 1);

  typedef enum logic [1:0] {
    OP_LOAD_AXIS = 2'd0,
    OP_TO_GLOBAL = 2'd1,
    OP_TO_LOCAL  = 2'd2,
    OP_BLOCK_ROW = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } st_t;

  // Operand source of a pass: axis column, axis row, or stored T column
  typedef enum logic [1:0] {
    MD_COL,
    MD_ROW,
    MD_FIN
  } md_t;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic [1:0]                    row_index;
    logic signed [VALUE_WIDTH-1:0] value_a;
    logic signed [VALUE_WIDTH-1:0] value_b;
    logic signed [VALUE_WIDTH-1:0] value_c;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] result_a;
    logic signed [VALUE_WIDTH-1:0] result_b;
    logic signed [VALUE_WIDTH-1:0] result_c;
    logic [1:0]                    result_row;
    logic                          saturated;
    logic                          last_of_run;
  } out_word_t;

  // One product step sent down every lane
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } issue_t;

  // What the merge stage does with the lane sums of the current pass
  typedef struct packed {
    logic       to_out;
    logic       store;
    logic       store_row;
    logic       keep_t2;
    logic       fold_clip;
    logic [1:0] res_row;
    logic       last;
  } pass_t;

  localparam pass_t VEC_PASS = '{to_out: 1'b1, store: 1'b0, store_row: 1'b0, keep_t2: 1'b0,
                                 fold_clip: 1'b0, res_row: 2'd0, last: 1'b1};
  localparam pass_t FIN_PASS = '{to_out: 1'b1, store: 1'b0, store_row: 1'b0, keep_t2: 1'b0,
                                 fold_clip: 1'b1, res_row: 2'd0, last: 1'b0};

endpackage

@@ rtl/btr_lane.sv @@
// One multiply-accumulate lane: three rounded data*axis products summed over three steps.
// Depends on btr_pkg for widths and the issue_t tag.
module btr_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btr_pkg::issue_t                     issue,
  input  logic signed [btr_pkg::DATA_W-1:0]   data,
  input  logic signed [btr_pkg::VALUE_WIDTH-1:0] axis,
  output logic                                done,
  output logic signed [btr_pkg::SUM_W-1:0]    total
);
  import btr_pkg::*;

  localparam logic signed [FULL_W-1:0] HALF =
    {{(FULL_W-AXIS_FRAC_BITS){1'b0}}, 1'b1, {(AXIS_FRAC_BITS-1){1'b0}}};

  logic signed [LO_W:0]        lo_s;
  logic signed [HI_W-1:0]      hi_s;
  logic signed [MLO_W-1:0]     mlo_r, mlo_nxt;
  logic signed [MHI_W-1:0]     mhi_r, mhi_nxt;
  logic signed [FULL_W-1:0]    full;
  logic signed [RND_W-1:0]     rnd_r, rnd_nxt;
  logic signed [SUM_W-1:0]     acc_r, acc_nxt;
  issue_t                      tag1_r, tag2_r;
  logic                        done_r;

  // Split the data word so each multiplier stays narrow
  assign lo_s    = signed'({1'b0, data[LO_W-1:0]});
  assign hi_s    = data[DATA_W-1:LO_W];
  assign mlo_nxt = MLO_W'(lo_s) * MLO_W'(axis);
  assign mhi_nxt = MHI_W'(hi_s) * MHI_W'(axis);

  // Join the partial products and round half up to the data format
  assign full    = (FULL_W'(mhi_r) <<< LO_W) + FULL_W'(mlo_r) + HALF;
  assign rnd_nxt = full[FULL_W-1:AXIS_FRAC_BITS];

  // Start a new sum on the first step, otherwise accumulate
  assign acc_nxt = tag2_r.first ? SUM_W'(rnd_r) : acc_r + SUM_W'(rnd_r);

  // Advance step tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag1_r <= issue;
      tag2_r <= tag1_r;
      done_r <= tag2_r.valid & tag2_r.last;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mlo_r <= mlo_nxt;
    mhi_r <= mhi_nxt;
    rnd_r <= rnd_nxt;
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign done  = done_r;
  assign total = acc_r;

endmodule

@@ rtl/btr_merge.sv @@
// Merge stage: saturates the lane sums, keeps the partial T rows, and builds the result word.
// Depends on btr_pkg for widths, pass_t and out_word_t.
module btr_merge (
  input  logic                                 clk,
  input  logic [btr_pkg::NUM_LANES-1:0]        lane_done,
  input  logic signed [btr_pkg::SUM_W-1:0]     lane_sum [btr_pkg::NUM_LANES],
  input  btr_pkg::pass_t                       pass,
  input  logic [1:0]                           sel_k,
  output logic                                 pass_done,
  output logic signed [btr_pkg::DATA_W-1:0]    t_data [btr_pkg::NUM_LANES],
  output logic                                 res_valid,
  output btr_pkg::out_word_t                   res_word
);
  import btr_pkg::*;

  localparam logic [VALUE_WIDTH-1:0]   V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0]   V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [PARTIAL_WIDTH-1:0] P_MAX = {1'b0, {(PARTIAL_WIDTH-1){1'b1}}};
  localparam logic [PARTIAL_WIDTH-1:0] P_MIN = {1'b1, {(PARTIAL_WIDTH-1){1'b0}}};

  logic signed [VALUE_WIDTH-1:0]   vsat [NUM_LANES];
  logic signed [PARTIAL_WIDTH-1:0] psat [NUM_LANES];
  logic [NUM_LANES-1:0]            vclip, pclip;
  logic signed [PARTIAL_WIDTH-1:0] part_r [2][NUM_LANES];
  logic [NUM_LANES-1:0]            pclip_r [2];
  logic signed [PARTIAL_WIDTH-1:0] t2_r [NUM_LANES];
  logic [NUM_LANES-1:0]            t2clip_r;
  logic                            fold;

  assign pass_done = &lane_done;

  for (genvar m = 0; m < NUM_LANES; m++) begin : g_sat
    logic [SUM_W-VALUE_WIDTH:0]   v_top;
    logic [SUM_W-PARTIAL_WIDTH:0] p_top;
    logic                         v_fit, p_fit;

    // Clip to the result width and to the partial row width
    assign v_top    = lane_sum[m][SUM_W-1:VALUE_WIDTH-1];
    assign v_fit    = (&v_top) | ~(|v_top);
    assign vsat[m]  = v_fit ? lane_sum[m][VALUE_WIDTH-1:0]
                            : (lane_sum[m][SUM_W-1] ? V_MIN : V_MAX);
    assign vclip[m] = ~v_fit;

    assign p_top    = lane_sum[m][SUM_W-1:PARTIAL_WIDTH-1];
    assign p_fit    = (&p_top) | ~(|p_top);
    assign psat[m]  = p_fit ? lane_sum[m][PARTIAL_WIDTH-1:0]
                            : (lane_sum[m][SUM_W-1] ? P_MIN : P_MAX);
    assign pclip[m] = ~p_fit;

    // Present T row k of column m to the operand select
    always_comb begin
      case (sel_k)
        2'd1:    t_data[m] = DATA_W'(part_r[1][m]);
        2'd2:    t_data[m] = DATA_W'(t2_r[m]);
        default: t_data[m] = DATA_W'(part_r[0][m]);
      endcase
    end
  end

  // Hold T rows 0 and 1 of the block, and row 2 while the block finishes
  always_ff @(posedge clk) begin
    if (pass_done && pass.store) begin
      part_r[pass.store_row]  <= psat;
      pclip_r[pass.store_row] <= pclip;
    end
    if (pass_done && pass.keep_t2) begin
      t2_r     <= psat;
      t2clip_r <= pclip;
    end
  end

  // Any clipped T entry marks every row of the finished block
  assign fold = pass.fold_clip & ((|pclip_r[0]) | (|pclip_r[1]) | (|t2clip_r));

  assign res_valid            = pass_done & pass.to_out;
  assign res_word.result_a    = vsat[0];
  assign res_word.result_b    = vsat[1];
  assign res_word.result_c    = vsat[2];
  assign res_word.result_row  = pass.res_row;
  assign res_word.saturated   = (|vclip) | fold;
  assign res_word.last_of_run = pass.last;

endmodule

@@ rtl/btr_ctrl.sv @@
// Sequencer: takes input words, holds the axis matrix, and steps the lanes through each pass.
// Depends on btr_pkg for state, mode, pass and word types.
module btr_ctrl (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  btr_pkg::in_word_t                      in_word,
  input  logic                                   out_free,
  input  logic                                   pass_done,
  input  logic signed [btr_pkg::DATA_W-1:0]      t_data [btr_pkg::NUM_LANES],
  output btr_pkg::issue_t                        issue,
  output logic signed [btr_pkg::DATA_W-1:0]      lane_data [btr_pkg::NUM_LANES],
  output logic signed [btr_pkg::VALUE_WIDTH-1:0] lane_axis [btr_pkg::NUM_LANES],
  output btr_pkg::pass_t                         pass,
  output logic [1:0]                             sel_k
);
  import btr_pkg::*;

  st_t                           state_r, state_nxt;
  md_t                           mode_r, mode_nxt;
  pass_t                         pass_r, pass_nxt;
  logic [1:0]                    k_r, k_nxt;
  logic [1:0]                    j_r, j_nxt;
  logic [1:0]                    j_inc;
  in_word_t                      item_r;
  logic signed [VALUE_WIDTH-1:0] axis_r [3][3];
  logic                          load_en;
  logic signed [VALUE_WIDTH-1:0] vk;
  logic signed [VALUE_WIDTH-1:0] fin_col [3];
  logic signed [VALUE_WIDTH-1:0] fin_ax;

  assign j_inc = j_r + 2'd1;

  // Next state and step issue
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    pass_nxt  = pass_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    in_stall  = 1'b1;
    load_en   = 1'b0;
    issue     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        k_nxt    = '0;
        if (in_valid) begin
          unique case (op_t'(in_word.opcode))
            OP_LOAD_AXIS: begin
              load_en = (in_word.row_index <= LAST_IDX);
            end
            OP_TO_GLOBAL: begin
              mode_nxt  = MD_COL;
              pass_nxt  = VEC_PASS;
              state_nxt = ST_ISSUE;
            end
            OP_TO_LOCAL: begin
              mode_nxt  = MD_ROW;
              pass_nxt  = VEC_PASS;
              state_nxt = ST_ISSUE;
            end
            OP_BLOCK_ROW: begin
              if (in_word.row_index <= LAST_IDX) begin
                mode_nxt           = MD_COL;
                pass_nxt           = '0;
                pass_nxt.store     = (in_word.row_index != LAST_IDX);
                pass_nxt.store_row = in_word.row_index[0];
                pass_nxt.keep_t2   = (in_word.row_index == LAST_IDX);
                state_nxt          = ST_ISSUE;
              end
            end
          endcase
        end
      end
      ST_ISSUE: begin
        // A pass that gives a result starts only once the output register has room
        if (k_r != '0 || !pass_r.to_out || out_free) begin
          issue.valid = 1'b1;
          issue.first = (k_r == '0);
          issue.last  = (k_r == LAST_IDX);
          if (k_r == LAST_IDX) begin
            k_nxt     = '0;
            state_nxt = ST_WAIT;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      ST_WAIT: begin
        if (pass_done) begin
          if (pass_r.keep_t2) begin
            mode_nxt  = MD_FIN;
            j_nxt     = '0;
            pass_nxt  = FIN_PASS;
            state_nxt = ST_ISSUE;
          end else if (mode_r == MD_FIN && j_r != LAST_IDX) begin
            j_nxt            = j_inc;
            pass_nxt.res_row = j_inc;
            pass_nxt.last    = (j_inc == LAST_IDX);
            state_nxt        = ST_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and axis matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MD_COL;
      pass_r  <= '0;
      k_r     <= '0;
      j_r     <= '0;
      axis_r  <= '{default: '0};
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      pass_r  <= pass_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      if (load_en) begin
        axis_r[in_word.row_index] <= '{in_word.value_a, in_word.value_b, in_word.value_c};
      end
    end
  end

  // Hold the accepted word for the whole run
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_word;
    end
  end

  // Input component of the current step
  always_comb begin
    case (k_r)
      2'd1:    vk = item_r.value_b;
      2'd2:    vk = item_r.value_c;
      default: vk = item_r.value_a;
    endcase
  end

  // Axis entry of row k, column j for the final block passes
  always_comb begin
    case (j_r)
      2'd1: begin
        fin_col[0] = axis_r[0][1];
        fin_col[1] = axis_r[1][1];
        fin_col[2] = axis_r[2][1];
      end
      2'd2: begin
        fin_col[0] = axis_r[0][2];
        fin_col[1] = axis_r[1][2];
        fin_col[2] = axis_r[2][2];
      end
      default: begin
        fin_col[0] = axis_r[0][0];
        fin_col[1] = axis_r[1][0];
        fin_col[2] = axis_r[2][0];
      end
    endcase
    case (k_r)
      2'd1:    fin_ax = fin_col[1];
      2'd2:    fin_ax = fin_col[2];
      default: fin_ax = fin_col[0];
    endcase
  end

  // Operand select for each lane
  for (genvar m = 0; m < NUM_LANES; m++) begin : g_sel
    logic signed [VALUE_WIDTH-1:0] col_ax, row_ax;

    always_comb begin
      case (k_r)
        2'd1: begin
          col_ax = axis_r[1][m];
          row_ax = axis_r[m][1];
        end
        2'd2: begin
          col_ax = axis_r[2][m];
          row_ax = axis_r[m][2];
        end
        default: begin
          col_ax = axis_r[0][m];
          row_ax = axis_r[m][0];
        end
      endcase
      case (mode_r)
        MD_ROW: begin
          lane_data[m] = DATA_W'(vk);
          lane_axis[m] = row_ax;
        end
        MD_FIN: begin
          lane_data[m] = t_data[m];
          lane_axis[m] = fin_ax;
        end
        default: begin
          lane_data[m] = DATA_W'(vk);
          lane_axis[m] = col_ax;
        end
      endcase
    end
  end

  assign pass  = pass_r;
  assign sel_k = k_r;

endmodule

@@ rtl/block_rotation_transform_unit.sv @@
// Top level of the block rotation transform unit: sequencer, three lanes, merge and output register.
// Depends on btr_pkg, btr_ctrl, btr_lane and btr_merge.
//
// Rotates 3-vectors between local and global axes and turns 3x3 stiffness blocks into
// R^T B R, all in Q15.16 with Q1.30 axis rows. Three lanes each own one result component
// and build it from three rounded products, accumulated in turn. Each product passes the
// partial product registers, the rounding register and the accumulator before the merged
// word is loaded into the output register. An axis load, or an ignored word with row index
// three, leaves the unit ready for the next word; a vector word and block rows 0 and 1
// keep the input stalled while their pass runs; block row 2 runs one pass for its own T
// row and then one pass per result row, and a result pass waits while the output register
// is full and stalled. A new word is taken while a finished result still waits at the output.
module block_rotation_transform_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  btr_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output btr_pkg::out_word_t out_word
);
  import btr_pkg::*;

  issue_t                        issue;
  logic signed [DATA_W-1:0]      lane_data [NUM_LANES];
  logic signed [VALUE_WIDTH-1:0] lane_axis [NUM_LANES];
  logic [NUM_LANES-1:0]          lane_done;
  logic signed [SUM_W-1:0]       lane_sum [NUM_LANES];
  logic signed [DATA_W-1:0]      t_data [NUM_LANES];
  pass_t                         pass;
  logic [1:0]                    sel_k;
  logic                          pass_done;
  logic                          res_valid;
  out_word_t                     res_word;
  logic                          out_valid_r;
  out_word_t                     out_word_r;
  logic                          out_free;

  assign out_free = !out_valid_r || !out_stall;

  btr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_free  (out_free),
    .pass_done (pass_done),
    .t_data    (t_data),
    .issue     (issue),
    .lane_data (lane_data),
    .lane_axis (lane_axis),
    .pass      (pass),
    .sel_k     (sel_k)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    btr_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .issue (issue),
      .data  (lane_data[g]),
      .axis  (lane_axis[g]),
      .done  (lane_done[g]),
      .total (lane_sum[g])
    );
  end

  btr_merge u_merge (
    .clk       (clk),
    .lane_done (lane_done),
    .lane_sum  (lane_sum),
    .pass      (pass),
    .sel_k     (sel_k),
    .pass_done (pass_done),
    .t_data    (t_data),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/btr_checker.sv @@
// Port-level checks for the block rotation transform unit, bound to the top level.
// Depends on btr_pkg and block_rotation_transform_unit.
module btr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input btr_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input btr_pkg::out_word_t out_word
);
  import btr_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // An axis load never holds up the next word
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.opcode == OP_LOAD_AXIS |=> !in_stall)
    else $error("axis load stalled the input");

  // A vector word keeps the input stalled while its pass runs
  a_vec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_word.opcode == OP_TO_GLOBAL || in_word.opcode == OP_TO_LOCAL) |=> in_stall)
    else $error("input taken during a vector pass");

  // Only results for rows 0 and 1 come out without the end-of-run mark
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last_of_run |->
    out_word.result_row == 2'd0 || out_word.result_row == 2'd1)
    else $error("unexpected row on a non-final result");

endmodule

bind block_rotation_transform_unit btr_checker u_btr_checker (.*);

@@ tb/sv/rotation_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the block rotation transform unit: watches both word channels,
// predicts every result from the accepted input words and compares in order.
// Depends on btr_pkg for the word structs, opcodes and number formats.
module rotation_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  btr_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  btr_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 results_owed
);
  import btr_pkg::*;

  typedef logic signed [127:0] acc_t;

  // Rotation rows (Q1.30) and stored T rows 0 and 1 with their clip flags
  logic signed [VALUE_WIDTH-1:0] axis_rows [9];
  logic signed [63:0]            t_rows    [6];
  bit                            t_clipped [6];
  out_word_t                     expected_results [$];

  // Product of data and an axis component, rounded half up to Q15.16
  function automatic acc_t rounded_product(input logic signed [63:0] data,
                                           input logic signed [VALUE_WIDTH-1:0] axis);
    acc_t d, a, half;
    d = 128'(data);
    a = 128'(axis);
    half = 1;
    half = half <<< (AXIS_FRAC_BITS - 1);
    return (d * a + half) >>> AXIS_FRAC_BITS;
  endfunction

  function automatic acc_t dot3(input logic signed [63:0] d0, d1, d2,
                                input logic signed [VALUE_WIDTH-1:0] r0, r1, r2);
    return rounded_product(d0, r0) + rounded_product(d1, r1) + rounded_product(d2, r2);
  endfunction

  // Clip a sum to n signed bits and flag the clip
  function automatic logic signed [63:0] clamp(input acc_t s, input int n, output bit hit);
    acc_t top, bottom;
    top = 1;
    top = (top <<< (n - 1)) - 1;
    bottom = -top - 1;
    hit = (s > top) || (s < bottom);
    if (s > top) return top[63:0];
    if (s < bottom) return bottom[63:0];
    return s[63:0];
  endfunction

  // Update the rotation state for one accepted word and queue the results it causes
  task automatic apply_rotation_word(input in_word_t w);
    logic signed [63:0] v [3];
    logic signed [63:0] t_new [3];
    logic signed [63:0] res [3];
    bit                 t_new_clip [3];
    bit                 hit, clip;
    acc_t               s;
    int                 row;
    v[0] = 64'(w.value_a);
    v[1] = 64'(w.value_b);
    v[2] = 64'(w.value_c);
    row = int'(w.row_index);
    case (w.opcode) inside
      OP_LOAD_AXIS: begin
        if (row < 3)
          for (int i = 0; i < 3; i++) axis_rows[row * 3 + i] = v[i][VALUE_WIDTH-1:0];
      end
      OP_TO_GLOBAL, OP_TO_LOCAL: begin
        clip = 0;
        for (int j = 0; j < 3; j++) begin
          if (w.opcode == OP_TO_GLOBAL)
            s = dot3(v[0], v[1], v[2], axis_rows[j], axis_rows[3 + j], axis_rows[6 + j]);
          else
            s = dot3(v[0], v[1], v[2], axis_rows[3 * j], axis_rows[3 * j + 1],
                     axis_rows[3 * j + 2]);
          res[j] = clamp(s, VALUE_WIDTH, hit);
          clip |= hit;
        end
        expected_results.push_back('{result_a: res[0][VALUE_WIDTH-1:0],
                                     result_b: res[1][VALUE_WIDTH-1:0],
                                     result_c: res[2][VALUE_WIDTH-1:0],
                                     result_row: 2'd0, saturated: clip, last_of_run: 1'b1});
      end
      OP_BLOCK_ROW: begin
        if (row < 3) begin
          // T row = block row times R
          for (int m = 0; m < 3; m++)
            t_new[m] = clamp(dot3(v[0], v[1], v[2], axis_rows[m], axis_rows[3 + m],
                                  axis_rows[6 + m]), PARTIAL_WIDTH, t_new_clip[m]);
          if (row < 2) begin
            for (int m = 0; m < 3; m++) begin
              t_rows[row * 3 + m]    = t_new[m];
              t_clipped[row * 3 + m] = t_new_clip[m];
            end
          end else begin
            // Row 2 closes the block: emit R^T T one row at a time
            for (int j = 0; j < 3; j++) begin
              clip = 0;
              for (int m = 0; m < 3; m++) begin
                clip |= t_clipped[m] | t_clipped[3 + m] | t_new_clip[m];
                res[m] = clamp(dot3(t_rows[m], t_rows[3 + m], t_new[m], axis_rows[j],
                                    axis_rows[3 + j], axis_rows[6 + j]), VALUE_WIDTH, hit);
                clip |= hit;
              end
              expected_results.push_back('{result_a: res[0][VALUE_WIDTH-1:0],
                                           result_b: res[1][VALUE_WIDTH-1:0],
                                           result_c: res[2][VALUE_WIDTH-1:0],
                                           result_row: 2'(j), saturated: clip,
                                           last_of_run: (j == 2)});
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Predict on accepted input words, compare on accepted result words
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) axis_rows[i] = '0;
      for (int i = 0; i < 6; i++) begin
        t_rows[i]    = '0;
        t_clipped[i] = 0;
      end
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) apply_rotation_word(in_word);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word a=%0d b=%0d c=%0d row=%0d sat=%0b last=%0b",
                   $time, out_word.result_a, out_word.result_b, out_word.result_c,
                   out_word.result_row, out_word.saturated, out_word.last_of_run);
        end else begin
          want = expected_results.pop_front();
          if (out_word.result_a !== want.result_a || out_word.result_b !== want.result_b ||
              out_word.result_c !== want.result_c || out_word.result_row !== want.result_row ||
              out_word.saturated !== want.saturated ||
              out_word.last_of_run !== want.last_of_run) begin
            fail_count++;
            $display("%0t: mismatch expected a=%0d b=%0d c=%0d row=%0d sat=%0b last=%0b",
                     $time, want.result_a, want.result_b, want.result_c, want.result_row,
                     want.saturated, want.last_of_run);
            $display("%0t:          actual a=%0d b=%0d c=%0d row=%0d sat=%0b last=%0b",
                     $time, out_word.result_a, out_word.result_b, out_word.result_c,
                     out_word.result_row, out_word.saturated, out_word.last_of_run);
          end
        end
      end
    end
    results_owed = expected_results.size();
  end

endmodule

@@ tb/sv/block_rotation_transform_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the block rotation transform unit testbench: clock, reset, input words and
// output stalls, with the verdict. Depends on btr_pkg, the unit and rotation_result_checker.
module block_rotation_transform_unit_tb;
  import btr_pkg::*;

  localparam int WORD_TARGET  = 450;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 48;

  localparam logic signed [31:0] AX_ONE  = 32'sh4000_0000;
  localparam logic signed [31:0] AX_HALF = 32'sh2000_0000;
  localparam logic signed [31:0] D_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] V_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] V_MIN   = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int fail_count;
  int results_owed;
  int cycle_count;
  int words_sent;
  bit quiet;
  bit t_row0_seen, t_row1_seen;

  always #4 clk = ~clk;

  block_rotation_transform_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  rotation_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  // Stall the result side at random, except in the quiet stretch
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 23);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] data_value();
    case ($urandom_range(9)) inside
      0: return V_MAX;
      1: return V_MIN;
      2, 3: return $urandom;
      default: return $signed($urandom) >>> 10;
    endcase
  endfunction

  function automatic logic signed [31:0] axis_value();
    case ($urandom_range(9))
      0: return AX_ONE;
      1: return -AX_ONE;
      2: return '0;
      3: return $urandom;
      4: return $urandom_range(1) ? V_MAX : V_MIN;
      default: return $signed($urandom) >>> 1;
    endcase
  endfunction

  // Send one word; entered and left at a falling edge
  task automatic send(input logic [1:0] op, input logic [1:0] row,
                      input logic signed [31:0] a, b, c);
    bit ignored;
    ignored = (op == OP_LOAD_AXIS || op == OP_BLOCK_ROW) && row == 2'd3;
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{opcode: op, row_index: row, value_a: a, value_b: b, value_c: c};
    do @(posedge clk); while (in_stall);
    if (!ignored) words_sent++;
    if (op == OP_BLOCK_ROW && row == 2'd0) t_row0_seen = 1;
    if (op == OP_BLOCK_ROW && row == 2'd1) t_row1_seen = 1;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [1:0] op, row;
    int         pick, n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero axes after reset, identity, extremes, ignored rows
    send(OP_TO_GLOBAL, 2'd0, D_ONE, -D_ONE, V_MAX);
    send(OP_LOAD_AXIS, 2'd0, AX_ONE, 0, 0);
    send(OP_LOAD_AXIS, 2'd1, 0, AX_ONE, 0);
    send(OP_LOAD_AXIS, 2'd2, 0, 0, AX_ONE);
    send(OP_TO_GLOBAL, 2'd0, D_ONE, V_MIN, V_MAX);
    send(OP_TO_LOCAL, 2'd3, V_MAX, V_MIN, 1);
    send(OP_LOAD_AXIS, 2'd3, V_MAX, V_MIN, V_MAX);
    send(OP_BLOCK_ROW, 2'd0, V_MAX, 0, V_MIN);
    send(OP_BLOCK_ROW, 2'd1, 1, -1, D_ONE);
    send(OP_BLOCK_ROW, 2'd3, V_MIN, V_MIN, V_MIN);
    send(OP_BLOCK_ROW, 2'd2, V_MIN, V_MAX, V_MAX);
    // Extreme axis row drives the sums into saturation
    send(OP_LOAD_AXIS, 2'd0, V_MAX, V_MIN, V_MAX);
    send(OP_TO_GLOBAL, 2'd2, V_MAX, V_MAX, V_MIN);
    send(OP_TO_LOCAL, 2'd1, V_MIN, V_MIN, V_MIN);
    send(OP_BLOCK_ROW, 2'd2, V_MAX, V_MAX, V_MAX);
    // Quarter turn about z, full block, then row 2 alone reusing stored rows
    send(OP_LOAD_AXIS, 2'd0, 0, AX_ONE, 0);
    send(OP_LOAD_AXIS, 2'd1, -AX_ONE, 0, 0);
    send(OP_LOAD_AXIS, 2'd2, 0, 0, AX_ONE);
    send(OP_BLOCK_ROW, 2'd0, D_ONE, 2 * D_ONE, 3 * D_ONE);
    send(OP_BLOCK_ROW, 2'd1, -4 * D_ONE, 5 * D_ONE, -6 * D_ONE);
    send(OP_BLOCK_ROW, 2'd2, 7 * D_ONE, -8 * D_ONE, 9 * D_ONE);
    send(OP_BLOCK_ROW, 2'd2, -1, 1, D_ONE);
    // Half-valued axes hit the round-half-up tie on tiny data
    send(OP_LOAD_AXIS, 2'd0, AX_HALF, -AX_HALF, AX_HALF);
    send(OP_LOAD_AXIS, 2'd1, AX_HALF, AX_HALF, 0);
    send(OP_LOAD_AXIS, 2'd2, 0, 0, -AX_HALF);
    send(OP_TO_GLOBAL, 2'd0, 1, -1, 3);
    send(OP_TO_LOCAL, 2'd0, -1, 1, -3);

    // Random: mostly axis loads, vector runs and blocks, some noise and broken blocks
    words_sent = 0;
    while (words_sent < WORD_TARGET) begin
      quiet = (words_sent >= 150 && words_sent < 230);
      pick = $urandom_range(99);
      if (pick < 15) begin
        op  = 2'($urandom_range(3));
        row = 2'($urandom_range(3));
        if (op == OP_BLOCK_ROW && row == 2'd2 && !(t_row0_seen && t_row1_seen)) row = 2'd0;
        send(op, row, data_value(), data_value(), data_value());
      end else if (pick < 30) begin
        for (int r = 0; r < 3; r++)
          send(OP_LOAD_AXIS, 2'(r), axis_value(), axis_value(), axis_value());
      end else if (pick < 60) begin
        n = $urandom_range(1, 4);
        repeat (n)
          send($urandom_range(1) ? OP_TO_GLOBAL : OP_TO_LOCAL, 2'($urandom_range(3)),
               data_value(), data_value(), data_value());
      end else begin
        for (int r = 0; r < 3; r++) begin
          // Skip a leading row now and then once both have been stored
          if (r < 2 && t_row0_seen && t_row1_seen && $urandom_range(9) == 0) continue;
          if ($urandom_range(19) == 0)
            send(OP_BLOCK_ROW, 2'd3, data_value(), data_value(), data_value());
          send(OP_BLOCK_ROW, 2'(r), data_value(), data_value(), data_value());
        end
      end
    end
    in_valid <= 1'b0;
    quiet = 0;

    // Drain, then allow for late extra results
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ block_rotation_transform_unit.f @@
rtl/btr_pkg.sv
rtl/btr_lane.sv
rtl/btr_merge.sv
rtl/btr_ctrl.sv
rtl/block_rotation_transform_unit.sv
rtl/btr_checker.sv
tb/sv/rotation_result_checker.sv
tb/sv/block_rotation_transform_unit_tb.sv
